// ===== design/kde_pkg.sv =====
// Shared types, widths and constants for the Gaussian KDE grid splat block.
// Holds the exp(-k/16) table builder used by the sweep engine.
// No dependencies.
package kde_pkg;

	localparam int GRID_SIDE = 64;
	localparam int SIDE_W = $clog2(GRID_SIDE);
	localparam int SIDEREG_W = SIDE_W + 1;
	localparam int ADDR_W = 2 * SIDE_W;
	localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
	localparam int ACC_W = 32;
	localparam int DENS_W = 17;
	localparam int COORD_W = 15;
	localparam int SPREAD_W = 16;
	localparam int REQ_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int EXP_DEPTH = 256;
	localparam int EXP_IDX_W = $clog2(EXP_DEPTH);
	localparam int EXP_VAL_W = 17;
	// sum of two squared 15-bit distances needs one extra bit
	localparam int R2_W = 2 * COORD_W + 1;
	localparam int PROD_W = R2_W + SPREAD_W;
	localparam int K_SHIFT = 28;
	localparam int K_W = PROD_W - K_SHIFT;
	localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

	localparam logic [CFG_IDX_W-1:0] CFG_INV_SPREAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIDE_IN_USE = 2'd1;

	localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_READ,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [SIDE_W-1:0]  row;
		logic [SIDE_W-1:0]  col;
	} item_t;

	typedef logic [EXP_VAL_W-1:0] exp_rom_t [EXP_DEPTH];

	// exp(-k/16) in Q1.16, built from a Q0.32 step recurrence
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t    rom;
		logic [63:0] v;
		logic [63:0] t;
		v = 64'd1 << 30;
		for (int k = 0; k < EXP_DEPTH; k++) begin
			t = (v + (64'd1 << 13)) >> 14;
			rom[k] = t[EXP_VAL_W-1:0];
			v = (v * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ===== design/gaussian_kde_grid_splat.sv =====
// Gaussian KDE grid splat, top level. Depends on kde_pkg, kde_front, kde_back.
// Operations: add sweeps side*side pixels (one pixel read-modify-write per cycle
// through the grid RAM port), read uses a 17-step divider, clear zeroes 4096 cells.
// Throughput: one request at a time in the engine; a 2-beat queue in front.
// Reset: async, active low; after reset a clearing pass over the whole grid
// RAM runs while in_stall is held high (config writes still taken).
module gaussian_kde_grid_splat (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [kde_pkg::REQ_W-1:0]       req_type,
	input  logic [kde_pkg::COORD_W-1:0]     x_coord,
	input  logic [kde_pkg::COORD_W-1:0]     y_coord,
	input  logic [kde_pkg::SIDE_W-1:0]      pixel_row,
	input  logic [kde_pkg::SIDE_W-1:0]      pixel_col,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [kde_pkg::DENS_W-1:0]      density_value,
	output logic                            saturated,
	// config write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [kde_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kde_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import kde_pkg::*;

	logic [SPREAD_W-1:0]  inv_spread_q;
	logic [SIDEREG_W-1:0] side_q;
	logic [SIDEREG_W-1:0] eff_side;
	logic                 head_valid;
	item_t                head;
	logic                 pop;
	logic                 init_busy;

	// config is always accepted; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_spread_q <= SPREAD_W'(32768);
			side_q <= SIDEREG_W'(GRID_SIDE);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_INV_SPREAD:  inv_spread_q <= cfg_data[SPREAD_W-1:0];
				CFG_SIDE_IN_USE: side_q <= cfg_data[SIDEREG_W-1:0];
				default: ;
			endcase
		end
	end

	// side clamps to the physical grid
	assign eff_side = (side_q > SIDEREG_W'(GRID_SIDE)) ? SIDEREG_W'(GRID_SIDE) : side_q;

	kde_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.pixel_row  (pixel_row),
		.pixel_col  (pixel_col),
		.hold       (init_busy),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	kde_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.inv_spread    (inv_spread_q),
		.eff_side      (eff_side),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.init_busy     (init_busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.density_value (density_value),
		.saturated     (saturated)
	);

endmodule

// ===== design/kde_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== design/kde_front.sv =====
// Front end: accepts request beats, decodes them and queues them for the engine.
// Depends on kde_pkg.
module kde_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [kde_pkg::REQ_W-1:0]     req_type,
	input  logic [kde_pkg::COORD_W-1:0]   x_coord,
	input  logic [kde_pkg::COORD_W-1:0]   y_coord,
	input  logic [kde_pkg::SIDE_W-1:0]    pixel_row,
	input  logic [kde_pkg::SIDE_W-1:0]    pixel_col,
	input  logic                          hold,
	output logic                          head_valid,
	output kde_pkg::item_t                head,
	input  logic                          pop
);
	import kde_pkg::*;

	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	item_t      item;

	always_comb begin
		item.x = x_coord;
		item.y = y_coord;
		item.row = pixel_row;
		item.col = pixel_col;
		case (req_type)
			REQ_ADD:   item.op = OP_ADD;
			REQ_READ:  item.op = OP_READ;
			REQ_CLEAR: item.op = OP_CLEAR;
			default:   item.op = OP_NOP;
		endcase
	end

	assign in_stall = hold || (count_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign head_valid = (count_q != 2'd0);
	assign head = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== design/kde_back.sv =====
// Back end: grid sweep pipeline, clear pass, pixel read divider and result slot.
// Depends on kde_pkg and kde_ram.
module kde_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [kde_pkg::SPREAD_W-1:0]   inv_spread,
	input  logic [kde_pkg::SIDEREG_W-1:0]  eff_side,
	input  logic                           head_valid,
	input  kde_pkg::item_t                 head,
	output logic                           pop,
	output logic                           init_busy,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [kde_pkg::DENS_W-1:0]     density_value,
	output logic                           saturated
);
	import kde_pkg::*;

	typedef enum logic [7:0] {
		ST_CLR   = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_ADD   = 8'b0000_0100,
		ST_DRAIN = 8'b0000_1000,
		ST_RDA   = 8'b0001_0000,
		ST_RDD   = 8'b0010_0000,
		ST_DIV   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t               state_q;
	logic                 init_q;
	logic [ADDR_W-1:0]    clr_cnt_q;
	logic [SIDE_W-1:0]    row_q;
	logic [SIDE_W-1:0]    col_q;
	logic [COORD_W-1:0]   px_q;
	logic [COORD_W-1:0]   py_q;
	logic [SIDE_W-1:0]    rrow_q;
	logic [SIDE_W-1:0]    rcol_q;
	logic [ACC_W-1:0]     peak_q;
	logic                 sat_q;
	logic [DENS_W-1:0]    res_q;
	logic [ACC_W-1:0]     rem_q;
	logic [DENS_W-1:0]    num_q;
	logic [DENS_W-1:0]    quo_q;
	logic [4:0]           div_cnt_q;

	// sweep pipeline
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [ADDR_W-1:0]    addr_s1, addr_s2, addr_s3, addr_s4;
	logic [COORD_W-1:0]   adx_s1, ady_s1;
	logic [R2_W-1:0]      r2_s2;
	logic [K_W-1:0]       k_s3;
	logic [EXP_VAL_W-1:0] g_s4;
	logic [ACC_W-1:0]     sum_s5;

	logic [COORD_W-1:0]   xj, yi;
	logic [PROD_W-1:0]    prod;
	logic [ACC_W:0]       sum_wide;
	logic [ACC_W-1:0]     sum_sat;
	logic                 sum_ovf;
	logic [ACC_W-1:0]     rd_data;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [ACC_W-1:0]     wr_data;
	logic                 last_px;
	logic                 pipe_busy;
	logic                 slot_free;
	logic [ACC_W:0]       trial;
	logic                 in_side;

	assign xj = COORD_W'({col_q, 8'b0});
	assign yi = COORD_W'({row_q, 8'b0});
	assign prod = PROD_W'(r2_s2) * PROD_W'(inv_spread);
	assign sum_wide = {1'b0, rd_data} + (ACC_W + 1)'(g_s4);
	assign sum_ovf = sum_wide[ACC_W];
	assign sum_sat = sum_ovf ? {ACC_W{1'b1}} : sum_wide[ACC_W-1:0];
	assign last_px = ({1'b0, row_q} == eff_side - 1'b1) && ({1'b0, col_q} == eff_side - 1'b1);
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign slot_free = !out_valid || !out_stall;
	assign trial = {rem_q, num_q[DENS_W-1]};
	assign in_side = ({1'b0, rrow_q} < eff_side) && ({1'b0, rcol_q} < eff_side);
	assign init_busy = init_q;
	assign pop = (state_q == ST_IDLE) && head_valid;

	assign rd_addr = (state_q == ST_RDA) ? {rrow_q, rcol_q} : addr_s3;

	always_comb begin
		if (state_q == ST_CLR) begin
			wr_en = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = '0;
		end else begin
			wr_en = v_s4;
			wr_addr = addr_s4;
			wr_data = sum_sat;
		end
	end

	kde_ram #(.WIDTH(ACC_W), .DEPTH(GRID_CELLS)) u_grid (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		addr_s1 <= {row_q, col_q};
		adx_s1 <= (xj >= px_q) ? xj - px_q : px_q - xj;
		ady_s1 <= (yi >= py_q) ? yi - py_q : py_q - yi;
		addr_s2 <= addr_s1;
		r2_s2 <= R2_W'(adx_s1) * R2_W'(adx_s1) + R2_W'(ady_s1) * R2_W'(ady_s1);
		addr_s3 <= addr_s2;
		k_s3 <= prod[PROD_W-1:K_SHIFT];
		addr_s4 <= addr_s3;
		g_s4 <= (k_s3 < K_W'(EXP_DEPTH)) ? EXP_ROM[k_s3[EXP_IDX_W-1:0]] : '0;
		sum_s5 <= sum_sat;
		if (state_q == ST_DONE && slot_free) begin
			density_value <= res_q;
			saturated <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			init_q <= 1'b1;
			clr_cnt_q <= '0;
			row_q <= '0;
			col_q <= '0;
			px_q <= '0;
			py_q <= '0;
			rrow_q <= '0;
			rcol_q <= '0;
			peak_q <= '0;
			sat_q <= 1'b0;
			res_q <= '0;
			rem_q <= '0;
			num_q <= '0;
			quo_q <= '0;
			div_cnt_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_ADD);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (v_s4 && sum_ovf) begin
				sat_q <= 1'b1;
			end
			if (v_s5 && sum_s5 > peak_q) begin
				peak_q <= sum_s5;
			end
			// result slot: loads in ST_DONE, holds while stalled
			out_valid <= (state_q == ST_DONE) || (out_valid && out_stall);

			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == ADDR_W'(GRID_CELLS - 1)) begin
						init_q <= 1'b0;
						res_q <= '0;
						state_q <= init_q ? ST_IDLE : ST_DONE;
					end
				end
				ST_IDLE: begin
					if (head_valid) begin
						case (head.op)
							OP_ADD: begin
								px_q <= head.x;
								py_q <= head.y;
								row_q <= '0;
								col_q <= '0;
								state_q <= (eff_side == '0) ? ST_DRAIN : ST_ADD;
							end
							OP_READ: begin
								rrow_q <= head.row;
								rcol_q <= head.col;
								state_q <= ST_RDA;
							end
							OP_CLEAR: begin
								clr_cnt_q <= '0;
								peak_q <= '0;
								sat_q <= 1'b0;
								state_q <= ST_CLR;
							end
							default: begin
								res_q <= '0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_ADD: begin
					if (last_px) begin
						state_q <= ST_DRAIN;
					end else if ({1'b0, col_q} == eff_side - 1'b1) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						res_q <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_RDA: begin
					state_q <= ST_RDD;
				end
				ST_RDD: begin
					if (!in_side || peak_q == '0) begin
						res_q <= '0;
						state_q <= ST_DONE;
					end else begin
						rem_q <= {1'b0, rd_data[ACC_W-1:1]};
						num_q <= {rd_data[0], 16'b0};
						quo_q <= '0;
						div_cnt_q <= 5'(DENS_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// one quotient bit per cycle, restoring
					if (trial >= {1'b0, peak_q}) begin
						rem_q <= ACC_W'(trial - {1'b0, peak_q});
						quo_q <= {quo_q[DENS_W-2:0], 1'b1};
						res_q <= {quo_q[DENS_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[ACC_W-1:0];
						quo_q <= {quo_q[DENS_W-2:0], 1'b0};
						res_q <= {quo_q[DENS_W-2:0], 1'b0};
					end
					num_q <= {num_q[DENS_W-2:0], 1'b0};
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
